// File: rtl/core/bmhq_pkg.sv
// Shared codes for the binary min-heap queue: request commands and result status.
// No dependencies; used by bmhq_ctrl and binary_min_heap_queue.
package bmhq_pkg;

  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_POP   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

endpackage

// File: rtl/core/bmhq_ram.sv
// Generic RAM: one write port, two read ports, read data registered.
// No dependencies.
module bmhq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: rtl/core/bmhq_ctrl.sv
// Heap sequencer: sift-up and sift-down over the entry RAM, fill count, root copy.
// Depends on bmhq_pkg for command and status codes.
module bmhq_ctrl #(
  parameter int CAPACITY = 256,
  parameter int KEY_BITS = 32,
  parameter int TAG_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      command,
  input  logic [KEY_BITS-1:0]             entry_key,
  input  logic [TAG_BITS-1:0]             entry_tag,
  output logic                            done,
  output logic [KEY_BITS-1:0]             top_key,
  output logic [TAG_BITS-1:0]             top_tag,
  output logic [$clog2(CAPACITY+1)-1:0]   count,
  output logic [1:0]                      status,
  output logic                            we,
  output logic [$clog2(CAPACITY)-1:0]     waddr,
  output logic [KEY_BITS+TAG_BITS-1:0]    wdata,
  output logic [$clog2(CAPACITY)-1:0]     raddr_a,
  output logic [$clog2(CAPACITY)-1:0]     raddr_b,
  input  logic [KEY_BITS+TAG_BITS-1:0]    rdata_a,
  input  logic [KEY_BITS+TAG_BITS-1:0]    rdata_b
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = AW + 2;
  localparam int EW = KEY_BITS + TAG_BITS;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_UP_RD   = 3'd1;
  localparam logic [2:0] S_UP_CMP  = 3'd2;
  localparam logic [2:0] S_DN_LAST = 3'd3;
  localparam logic [2:0] S_DN_RD   = 3'd4;
  localparam logic [2:0] S_DN_CMP  = 3'd5;

  logic [2:0]          state, state_next;
  logic [AW-1:0]       pos, pos_next;
  logic [CW-1:0]       count_next;
  logic [KEY_BITS-1:0] mov_key, mov_key_next;
  logic [TAG_BITS-1:0] mov_tag, mov_tag_next;
  logic [1:0]          status_next;
  logic                done_next;

  logic [AW-1:0]       up_idx;
  logic [IW-1:0]       l_idx, r_idx, count_ext;
  logic [CW-1:0]       count_dec;
  logic [KEY_BITS-1:0] key_a, key_b, pick_key;
  logic                has_r, pick_l;

  assign up_idx    = AW'((pos - AW'(1)) >> 1);
  assign l_idx     = {1'b0, pos, 1'b1};
  assign r_idx     = l_idx + IW'(1);
  assign count_ext = IW'(count);
  assign count_dec = count - CW'(1);
  assign key_a     = rdata_a[EW-1:TAG_BITS];
  assign key_b     = rdata_b[EW-1:TAG_BITS];
  assign has_r     = r_idx < count_ext;
  // right child wins ties
  assign pick_l    = !has_r || (key_a < key_b);
  assign pick_key  = pick_l ? key_a : key_b;
  assign busy      = (state != S_IDLE);

  always_comb begin
    state_next   = state;
    pos_next     = pos;
    count_next   = count;
    mov_key_next = mov_key;
    mov_tag_next = mov_tag;
    status_next  = status;
    done_next    = 1'b0;
    we           = 1'b0;
    waddr        = pos;
    wdata        = {mov_key, mov_tag};
    raddr_a      = up_idx;
    raddr_b      = r_idx[AW-1:0];

    case (state)
      S_IDLE: begin
        raddr_a = count_dec[AW-1:0];
        if (start) begin
          status_next = bmhq_pkg::ST_DONE;
          case (command)
            bmhq_pkg::CMD_PUSH: begin
              if (count == CW'(CAPACITY)) begin
                status_next = bmhq_pkg::ST_FULL;
                done_next   = 1'b1;
              end else begin
                mov_key_next = entry_key;
                mov_tag_next = entry_tag;
                pos_next     = count[AW-1:0];
                count_next   = count + CW'(1);
                state_next   = S_UP_RD;
              end
            end
            bmhq_pkg::CMD_POP: begin
              if (count == '0) begin
                status_next = bmhq_pkg::ST_EMPTY;
                done_next   = 1'b1;
              end else begin
                count_next = count_dec;
                pos_next   = '0;
                if (count_dec == '0) begin
                  done_next = 1'b1;
                end else begin
                  // last slot is being read this cycle
                  state_next = S_DN_LAST;
                end
              end
            end
            bmhq_pkg::CMD_CLEAR: begin
              count_next = '0;
              done_next  = 1'b1;
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      S_UP_RD: begin
        if (pos == '0) begin
          we         = 1'b1;
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (mov_key < key_a) begin
          wdata      = rdata_a;
          pos_next   = up_idx;
          state_next = S_UP_RD;
        end else begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DN_LAST: begin
        mov_key_next = key_a;
        mov_tag_next = rdata_a[TAG_BITS-1:0];
        state_next   = S_DN_RD;
      end
      S_DN_RD: begin
        raddr_a = l_idx[AW-1:0];
        if (l_idx >= count_ext) begin
          we         = 1'b1;
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        we = 1'b1;
        if (pick_key < mov_key) begin
          wdata      = pick_l ? rdata_a : rdata_b;
          pos_next   = pick_l ? l_idx[AW-1:0] : r_idx[AW-1:0];
          state_next = S_DN_RD;
        end else begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      done   <= 1'b0;
      status <= bmhq_pkg::ST_DONE;
    end else begin
      state  <= state_next;
      count  <= count_next;
      done   <= done_next;
      status <= status_next;
    end
    pos     <= pos_next;
    mov_key <= mov_key_next;
    mov_tag <= mov_tag_next;
    // shadow copy of slot 0 for the result
    if (we && waddr == '0) begin
      top_key <= wdata[EW-1:TAG_BITS];
      top_tag <= wdata[TAG_BITS-1:0];
    end
  end

endmodule

// File: rtl/core/binary_min_heap_queue.sv
// Binary min-heap queue. Push starts the entry at the next free slot and sifts it up toward
// the root; pop moves the last entry to the root and sifts it down until it reaches a leaf or
// stops above one. Full push, empty pop, pop of the last entry, clear and unused commands are
// answered from idle. Worst case is a push into the last slot climbing to the root.
// One request in flight: the next is taken at the edge that ends the done cycle; results
// cannot be held off. Sync reset empties the heap, RAM contents are not cleared.
module binary_min_heap_queue #(
  parameter int CAPACITY = 256,
  parameter int KEY_BITS = 32,
  parameter int TAG_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    command,
  input  logic [KEY_BITS-1:0]           entry_key,
  input  logic [TAG_BITS-1:0]           entry_tag,
  output logic                          done,
  output logic [KEY_BITS-1:0]           top_key,
  output logic [TAG_BITS-1:0]           top_tag,
  output logic                          is_empty,
  output logic [$clog2(CAPACITY+1)-1:0] entry_count,
  output logic [1:0]                    status
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = KEY_BITS + TAG_BITS;

  logic                we;
  logic [AW-1:0]       waddr, raddr_a, raddr_b;
  logic [EW-1:0]       wdata, rdata_a, rdata_b;
  logic [KEY_BITS-1:0] root_key;
  logic [TAG_BITS-1:0] root_tag;

  bmhq_ctrl #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS),
    .TAG_BITS (TAG_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .command   (command),
    .entry_key (entry_key),
    .entry_tag (entry_tag),
    .done      (done),
    .top_key   (root_key),
    .top_tag   (root_tag),
    .count     (entry_count),
    .status    (status),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .raddr_a   (raddr_a),
    .raddr_b   (raddr_b),
    .rdata_a   (rdata_a),
    .rdata_b   (rdata_b)
  );

  bmhq_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  assign is_empty = (entry_count == '0);
  assign top_key  = is_empty ? '0 : root_key;
  assign top_tag  = is_empty ? '0 : root_tag;

`ifndef NO_ASSERTIONS
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted request neither busy nor done");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while sequencer busy");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && status == bmhq_pkg::ST_FULL) |-> (entry_count == CW'(CAPACITY)))
    else $error("push rejected while heap not full");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (done && status == bmhq_pkg::ST_EMPTY) |-> (entry_count == '0))
    else $error("pop flagged empty while heap holds entries");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(CAPACITY))
    else $error("fill count exceeds capacity");
`endif

endmodule
